>>> hw/rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, codes and the character classifier of the base64 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

	// Symbol values of the two punctuation characters of the alphabet.
	localparam logic [5:0] SYM_PLUS  = 6'd62;
	localparam logic [5:0] SYM_SLASH = 6'd63;

	// Saturation value of the byte counter.
	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	// Class of one character after the alphabet lookup.
	typedef enum logic [1:0] {
		KIND_SYM  = 2'd0,
		KIND_SKIP = 2'd1,
		KIND_BAD  = 2'd2
	} kind_t;

	// Input beat: one character and the stream start flag.
	typedef struct packed {
		logic [7:0] in_char;
		logic       stream_start;
	} in_beat_t;

	// Output beat: one decoded byte or the halt mark.
	typedef struct packed {
		logic [7:0]  out_byte;
		logic        halted;
		logic [31:0] byte_total;
	} out_beat_t;

	// Classified command passed from the front to the back.
	typedef struct packed {
		kind_t      kind;
		logic [5:0] sym;
		logic       start;
	} cmd_t;

	// Maps one character through the standard base64 alphabet.
	function automatic cmd_t classify(input logic [7:0] c, input logic start);
		cmd_t r;
		r.start = start;
		r.sym   = '0;
		r.kind  = KIND_BAD;
		case (c) inside
			// Upper case letters give 0 to 25.
			[8'h41:8'h5A]: begin
				r.kind = KIND_SYM;
				r.sym  = 6'(c - 8'h41);
			end
			// Lower case letters give 26 to 51.
			[8'h61:8'h7A]: begin
				r.kind = KIND_SYM;
				r.sym  = 6'(c - 8'h47);
			end
			// Digits give 52 to 61.
			[8'h30:8'h39]: begin
				r.kind = KIND_SYM;
				r.sym  = 6'(c + 8'h04);
			end
			8'h2B: begin
				r.kind = KIND_SYM;
				r.sym  = SYM_PLUS;
			end
			8'h2F: begin
				r.kind = KIND_SYM;
				r.sym  = SYM_SLASH;
			end
			// Space, tab, LF and CR.
			8'h20, 8'h09, 8'h0A, 8'h0D: begin
				r.kind = KIND_SKIP;
			end
			default: begin
				r.kind = KIND_BAD;
			end
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts character beats, classifies them and hands commands to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_front import b64d_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire in_beat_t in_beat,
	input  wire logic     q_full,
	output logic          q_push,
	output cmd_t          q_cmd
);

	cmd_t cmd_now;
	logic keep_now;
	logic valid_s1;
	cmd_t cmd_s1;

	// Classify the incoming character; whitespace without the start flag never reaches the back.
	always_comb begin
		cmd_now  = classify(in_beat.in_char, in_beat.stream_start);
		keep_now = (cmd_now.kind != KIND_SKIP) || cmd_now.start;
	end

	// The stage holds while the queue cannot take its command.
	assign in_stall = valid_s1 && q_full;
	assign q_push   = valid_s1 && !q_full;
	assign q_cmd    = cmd_s1;

	// Control of the classify stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid && keep_now;
		end
	end

	// Payload of the classify stage.
	always_ff @(posedge clk) begin
		if (!in_stall) begin
			cmd_s1 <= cmd_now;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_queue import b64d_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output cmd_t      pop_cmd,
	output logic      full,
	output logic      empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign pop_cmd = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Command storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Decoder state update and the output register of the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_back import b64d_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_empty,
	input  wire cmd_t q_cmd,
	output logic      q_pop,
	output logic      out_valid,
	input  wire logic out_stall,
	output out_beat_t out_beat
);

	logic [11:0] acc_q;
	logic [3:0]  cnt_q;
	logic        stopped_q;
	logic [31:0] total_q;
	logic        out_valid_q;
	out_beat_t   out_q;

	logic [11:0] acc_cur, acc_nxt;
	logic [3:0]  cnt_cur, cnt_nxt, cnt_sum;
	logic        stopped_cur, stopped_nxt;
	logic [31:0] total_cur, total_nxt;
	logic        res_valid;
	out_beat_t   res;
	logic [11:0] acc_shifted;

	// A command is taken whenever the output register is free or drains.
	assign q_pop = !q_empty && (!out_valid_q || !out_stall);

	// Next decoder state and the result of the popped command.
	always_comb begin
		acc_cur     = q_cmd.start ? '0 : acc_q;
		cnt_cur     = q_cmd.start ? '0 : cnt_q;
		stopped_cur = q_cmd.start ? 1'b0 : stopped_q;
		total_cur   = q_cmd.start ? '0 : total_q;

		acc_nxt     = acc_cur;
		cnt_nxt     = cnt_cur;
		stopped_nxt = stopped_cur;
		total_nxt   = total_cur;
		res_valid   = 1'b0;
		res         = '0;
		cnt_sum     = cnt_cur + 4'd6;
		acc_shifted = '0;

		if (!stopped_cur) begin
			case (q_cmd.kind)
				KIND_SYM: begin
					acc_nxt = {acc_cur[5:0], q_cmd.sym};
					if (cnt_sum >= 4'd8) begin
						cnt_nxt     = cnt_sum - 4'd8;
						total_nxt   = (total_cur == COUNT_MAX) ? total_cur
							: total_cur + 32'd1;
						acc_shifted = acc_nxt >> cnt_nxt;
						res_valid   = 1'b1;
						res.out_byte   = acc_shifted[7:0];
						res.halted     = 1'b0;
						res.byte_total = total_nxt;
					end else begin
						cnt_nxt = cnt_sum;
					end
				end
				KIND_SKIP: begin
					res_valid = 1'b0;
				end
				default: begin
					// Terminator or invalid character: drop pending bits and halt.
					stopped_nxt    = 1'b1;
					acc_nxt        = '0;
					cnt_nxt        = '0;
					res_valid      = 1'b1;
					res.out_byte   = '0;
					res.halted     = 1'b1;
					res.byte_total = total_cur;
				end
			endcase
		end
	end

	// Decoder state and output control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			cnt_q       <= '0;
			stopped_q   <= 1'b0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				acc_q     <= acc_nxt;
				cnt_q     <= cnt_nxt;
				stopped_q <= stopped_nxt;
				total_q   <= total_nxt;
			end
			if (!out_valid_q || !out_stall) begin
				out_valid_q <= q_pop && res_valid;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (q_pop && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_q;

`ifndef SYNTHESIS
	// A held result is never overwritten by a new command.
	a_no_pop_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && out_valid_q && out_stall))
		else $error("command popped while the output beat was held");

	// The halted state carries no pending bits.
	a_stopped_clean: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> (cnt_q == '0) && (acc_q == '0))
		else $error("pending bits kept after halt");

	// Entering the halted state presents exactly the halt beat.
	a_halt_beat: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(stopped_q) |-> out_valid_q && out_q.halted && (out_q.out_byte == '0))
		else $error("halt entered without a halt beat");

	// Pending bit count stays even and below one byte.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (cnt_q[0] == 1'b0) && (cnt_q <= 4'd6))
		else $error("pending bit count out of range");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder: one ASCII character in, at most one byte out.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_beat) takes one character per
//   beat together with a stream start flag that clears the decoder state
//   before that character. The output channel (out_valid, out_stall,
//   out_beat) gives one beat per decoded byte and one halt beat when a
//   terminator or invalid character stops the stream; whitespace gives none.
//   Throughput is one character per cycle while neither side stalls, set
//   by the state update in the back stage. A result passes from the
//   classify register through the command queue into the output register.
//   When the receiver stalls, the output register holds its beat; the queue
//   of QUEUE_DEPTH commands fills next, and then in_stall rises.
//   Reset clears the accumulator, bit count, halt flag and byte count and
//   empties every stage; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_decoder import b64d_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire in_beat_t  in_beat,
	output logic           out_valid,
	input  wire logic      out_stall,
	output out_beat_t      out_beat
);

	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	cmd_t push_cmd;
	cmd_t pop_cmd;

	b64d_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_beat  (in_beat),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	b64d_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.pop_cmd  (pop_cmd),
		.full     (q_full),
		.empty    (q_empty)
	);

	b64d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_cmd     (pop_cmd),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat)
	);

endmodule

`default_nettype wire
